// ===== design/tec_pkg.sv =====
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types and constants of the tiny 8-bit CPU execute core: opcode
// encodings, the decoded instruction format and the decode queue size.
// ----------------------------------------------------------------------------
package tec_pkg;

  // Opcode field, instruction bits 7:5.
  localparam logic [2:0] OPC_HALT_LO = 3'b000;
  localparam logic [2:0] OPC_MOV     = 3'b001;
  localparam logic [2:0] OPC_ADD     = 3'b010;
  localparam logic [2:0] OPC_SUB     = 3'b011;
  localparam logic [2:0] OPC_LD      = 3'b100;
  localparam logic [2:0] OPC_ST      = 3'b101;
  localparam logic [2:0] OPC_BR      = 3'b110;
  localparam logic [2:0] OPC_HALT_HI = 3'b111;

  localparam int NUM_REGS = 4;
  localparam int REG_IDX_W = 2;

  // Decode queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [2:0] {
    OP_HALT,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_LD,
    OP_ST,
    OP_BR
  } op_t;

  // Decoded instruction. For MOV the immediate is three bits wide, for the
  // other operand forms it holds the two low instruction bits.
  typedef struct packed {
    op_t                  op;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [REG_IDX_W-1:0] src_idx;
    logic                 use_imm;
    logic [2:0]           imm;
    logic [4:0]           br_off;
  } dec_t;

endpackage

// ===== design/tec_front.sv =====
// ----------------------------------------------------------------------------
// tec_front
// Front end: accepts instruction bytes and decodes them into the queue.
// ----------------------------------------------------------------------------
module tec_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_instr,
  input  logic              q_full,
  output logic              q_push,
  output tec_pkg::dec_t     q_push_data
);

  tec_pkg::dec_t dec;

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_push_data = dec;

  always_comb begin
    dec         = '0;
    dec.op      = tec_pkg::OP_HALT;
    dec.wr_idx  = in_instr[3:2];
    dec.src_idx = in_instr[1:0];
    dec.use_imm = in_instr[4];
    dec.imm     = {1'b0, in_instr[1:0]};
    dec.br_off  = in_instr[4:0];
    case (in_instr[7:5])
      tec_pkg::OPC_MOV: begin
        dec.op      = tec_pkg::OP_MOV;
        dec.wr_idx  = in_instr[4:3];
        dec.use_imm = 1'b1;
        dec.imm     = in_instr[2:0];
      end
      tec_pkg::OPC_ADD: dec.op = tec_pkg::OP_ADD;
      tec_pkg::OPC_SUB: dec.op = tec_pkg::OP_SUB;
      tec_pkg::OPC_LD:  dec.op = tec_pkg::OP_LD;
      tec_pkg::OPC_ST:  dec.op = tec_pkg::OP_ST;
      tec_pkg::OPC_BR:  dec.op = tec_pkg::OP_BR;
      tec_pkg::OPC_HALT_LO, tec_pkg::OPC_HALT_HI: dec.op = tec_pkg::OP_HALT;
      default: dec.op = tec_pkg::OP_HALT;
    endcase
  end

endmodule

// ===== design/tec_queue.sv =====
// ----------------------------------------------------------------------------
// tec_queue
// Small FIFO of decoded instructions between the front and back ends.
// ----------------------------------------------------------------------------
module tec_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tec_pkg::dec_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tec_pkg::dec_t head_data
);

  tec_pkg::dec_t                   entry_r [tec_pkg::Q_DEPTH];
  logic [tec_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tec_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tec_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  assign full       = (count_r == tec_pkg::Q_CNT_W'(tec_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/tec_back.sv =====
// ----------------------------------------------------------------------------
// tec_back
// Back end: executes the queue head against the register file, data memory
// and program counter, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tec_back #(
  parameter int MEM_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  tec_pkg::dec_t head_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_halted,
  output logic [7:0]    out_next_pc,
  output logic          out_reg_written,
  output logic [1:0]    out_reg_index,
  output logic [7:0]    out_reg_value,
  output logic          out_mem_written,
  output logic [7:0]    out_mem_addr,
  output logic [7:0]    out_mem_value
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef struct packed {
    logic       halted;
    logic [7:0] next_pc;
    logic       reg_written;
    logic [1:0] reg_index;
    logic [7:0] reg_value;
    logic       is_load;
    logic       mem_written;
    logic [7:0] mem_addr;
    logic [7:0] mem_value;
  } res_t;

  logic [7:0]           regs_r [tec_pkg::NUM_REGS];
  logic [7:0]           mem    [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_r;
  logic [7:0]           rdata_r;
  logic                 rd_vld_r;
  logic                 ld_pend_r, ld_pend_nxt;
  logic [1:0]           ld_dst_r;
  logic [7:0]           pc_r, pc_nxt;
  logic                 stop_r, stop_nxt;
  logic                 res_valid_r, res_valid_nxt;
  res_t                 res_r, res_nxt;

  logic [AW-1:0]        addr_mod [256];
  logic [7:0]           load_val;
  logic [7:0]           opa, opb, alu_val, wr_val;
  logic                 stopped, reg_wr, mem_wr, fire;
  logic signed [9:0]    npc;
  logic [AW-1:0]        maddr;

  // Address reduction modulo the memory depth, a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign addr_mod[g] = AW'(g % MEM_DEPTH);
  end

  assign load_val = rd_vld_r ? rdata_r : 8'h00;
  assign fire     = head_valid && (!res_valid_r || out_ready);
  assign pop      = fire;

  // Register read with bypass of a load that completes this cycle.
  function automatic logic [7:0] rd_reg(input logic [1:0] idx,
                                        input logic [7:0] r0, input logic [7:0] r1,
                                        input logic [7:0] r2, input logic [7:0] r3,
                                        input logic pend, input logic [1:0] pdst,
                                        input logic [7:0] pval);
    logic [7:0] v;
    case (idx)
      2'd0:    v = r0;
      2'd1:    v = r1;
      2'd2:    v = r2;
      default: v = r3;
    endcase
    if (pend && (pdst == idx)) begin
      v = pval;
    end
    return v;
  endfunction

  always_comb begin
    opa = rd_reg(head_data.wr_idx, regs_r[0], regs_r[1], regs_r[2], regs_r[3],
                 ld_pend_r, ld_dst_r, load_val);
    opb = head_data.use_imm ? {5'b0, head_data.imm}
                            : rd_reg(head_data.src_idx, regs_r[0], regs_r[1], regs_r[2],
                                     regs_r[3], ld_pend_r, ld_dst_r, load_val);
    alu_val = (head_data.op == tec_pkg::OP_SUB) ? (opa - opb) : (opa + opb);
    maddr   = addr_mod[opb];
    stopped = stop_r || (head_data.op == tec_pkg::OP_HALT);
    npc     = $signed({2'b00, pc_r}) +
              ((head_data.op == tec_pkg::OP_BR) ?
               {{5{head_data.br_off[4]}}, head_data.br_off} : 10'sd1);

    reg_wr = !stopped && ((head_data.op == tec_pkg::OP_MOV) ||
                          (head_data.op == tec_pkg::OP_ADD) ||
                          (head_data.op == tec_pkg::OP_SUB));
    mem_wr = !stopped && (head_data.op == tec_pkg::OP_ST);
    wr_val = (head_data.op == tec_pkg::OP_MOV) ? {5'b0, head_data.imm} : alu_val;

    pc_nxt        = pc_r;
    stop_nxt      = stop_r;
    ld_pend_nxt   = 1'b0;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !out_ready;
    if (fire) begin
      res_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (stopped) begin
        stop_nxt = 1'b1;
      end else begin
        pc_nxt   = npc[7:0];
        stop_nxt = (npc[9:8] != 2'b00);
        case (head_data.op)
          tec_pkg::OP_MOV, tec_pkg::OP_ADD, tec_pkg::OP_SUB: begin
            res_nxt.reg_written = 1'b1;
            res_nxt.reg_index   = head_data.wr_idx;
            res_nxt.reg_value   = wr_val;
          end
          tec_pkg::OP_LD: begin
            ld_pend_nxt         = 1'b1;
            res_nxt.reg_written = 1'b1;
            res_nxt.reg_index   = head_data.wr_idx;
            res_nxt.is_load     = 1'b1;
          end
          tec_pkg::OP_ST: begin
            res_nxt.mem_written = 1'b1;
            res_nxt.mem_addr    = 8'(maddr);
            res_nxt.mem_value   = opa;
          end
          default: ;
        endcase
      end
      res_nxt.halted  = stop_nxt;
      res_nxt.next_pc = pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      stop_r      <= 1'b0;
      ld_pend_r   <= 1'b0;
      res_valid_r <= 1'b0;
      mem_vld_r   <= '0;
      for (int i = 0; i < tec_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      pc_r        <= pc_nxt;
      stop_r      <= stop_nxt;
      ld_pend_r   <= ld_pend_nxt;
      res_valid_r <= res_valid_nxt;
      if (fire && mem_wr) begin
        mem_vld_r[maddr] <= 1'b1;
      end
      // A write from the executing instruction is younger than a load that
      // completes in the same cycle, so it takes priority.
      for (int i = 0; i < tec_pkg::NUM_REGS; i++) begin
        if (fire && reg_wr && (head_data.wr_idx == 2'(i))) begin
          regs_r[i] <= wr_val;
        end else if (ld_pend_r && (ld_dst_r == 2'(i))) begin
          regs_r[i] <= load_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r    <= res_nxt;
      ld_dst_r <= head_data.wr_idx;
      rdata_r  <= mem[maddr];
      rd_vld_r <= mem_vld_r[maddr];
      if (mem_wr) begin
        mem[maddr] <= opa;
      end
    end
  end

  assign out_valid       = res_valid_r;
  assign out_halted      = res_r.halted;
  assign out_next_pc     = res_r.next_pc;
  assign out_reg_written = res_r.reg_written;
  assign out_reg_index   = res_r.reg_index;
  assign out_reg_value   = res_r.is_load ? load_val : res_r.reg_value;
  assign out_mem_written = res_r.mem_written;
  assign out_mem_addr    = res_r.mem_addr;
  assign out_mem_value   = res_r.mem_value;

endmodule

// ===== design/tiny_eight_bit_cpu_execute_core.sv =====
// ----------------------------------------------------------------------------
// tiny_eight_bit_cpu_execute_core
// Execute core of a tiny 8-bit processor with four registers and a data
// memory, one result item per instruction item.
// ----------------------------------------------------------------------------
// Each input item is one instruction byte and yields exactly one result item
// that reports the next program counter, the halt status and any register or
// memory write. The core sustains one item per clock cycle while out_ready
// stays high: the decoder writes a two-entry queue, and the execute stage
// retires the queue head in the cycle it moves into the output register, so
// a result is presented once its item has passed the queue entry and the
// output register. Throughput is set by the single execute stage and its
// one data memory port; a stalled output fills the queue, and in_ready falls
// only once both queue entries are occupied. Loads read the data memory
// through a registered port and the loaded byte is bypassed to the next
// instruction, so dependent instructions issue without bubbles.
// Data memory starts as all zero after reset through per-entry valid bits,
// so no clearing pass is needed and items are accepted right after reset.
// Once a halt opcode is executed or the program counter leaves 0..255, the
// core stays halted: every further item is answered with halted set, the
// held program counter and no writes, until the next reset.
// ----------------------------------------------------------------------------
module tiny_eight_bit_cpu_execute_core #(
  parameter int MEM_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_instr,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_halted,
  output logic [7:0] out_next_pc,
  output logic       out_reg_written,
  output logic [1:0] out_reg_index,
  output logic [7:0] out_reg_value,
  output logic       out_mem_written,
  output logic [7:0] out_mem_addr,
  output logic [7:0] out_mem_value
);

  // Queue write side from the decoder.
  logic          q_push;
  logic          q_full;
  tec_pkg::dec_t q_push_data;

  // Queue read side toward the execute stage.
  logic          q_pop;
  logic          q_head_valid;
  tec_pkg::dec_t q_head_data;

  tec_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_instr    (in_instr),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  tec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // The execute stage owns all architectural state: registers, data memory,
  // program counter and the sticky halt flag.
  tec_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_data       (q_head_data),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_halted      (out_halted),
    .out_next_pc     (out_next_pc),
    .out_reg_written (out_reg_written),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_mem_written (out_mem_written),
    .out_mem_addr    (out_mem_addr),
    .out_mem_value   (out_mem_value)
  );

endmodule

// ===== design/tec_checker.sv =====
// ----------------------------------------------------------------------------
// tec_checker
// Port-level checks of the execute core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_halted,
  input logic [7:0] out_next_pc,
  input logic       out_reg_written,
  input logic       out_mem_written
);

  logic       seen_halt_r;
  logic [7:0] halt_pc_r;
  logic [2:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
      halt_pc_r   <= '0;
      pending_r   <= '0;
    end else begin
      if (out_valid && out_ready && out_halted && !seen_halt_r) begin
        seen_halt_r <= 1'b1;
        halt_pc_r   <= out_next_pc;
      end
      pending_r <= pending_r + 3'((in_valid && in_ready) ? 1 : 0)
                             - 3'((out_valid && out_ready) ? 1 : 0);
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_halted))
    else $error("result changed while stalled");

  // Halting is sticky and freezes the program counter with no writes.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> out_halted && out_next_pc == halt_pc_r &&
                                 !out_reg_written && !out_mem_written)
    else $error("item after halt was executed");

  // An instruction never writes a register and memory at once.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reg_written && out_mem_written))
    else $error("register and memory written together");

  // No result without an item, and at most queue plus output in flight.
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> pending_r != 3'd0) and (pending_r <= 3'd3))
    else $error("item count mismatch between input and output");

endmodule

bind tiny_eight_bit_cpu_execute_core tec_checker u_tec_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_halted      (out_halted),
  .out_next_pc     (out_next_pc),
  .out_reg_written (out_reg_written),
  .out_mem_written (out_mem_written)
);
